FILE: sv/htd_pkg.sv
`timescale 1ns / 1ps

package htd_pkg;

    localparam int NODE_COUNT = 512;
    localparam int NODE_AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    localparam int IDX_W      = 9;
    localparam int SYM_W      = 8;
    localparam int PAD_W      = 3;
    localparam int BITS_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_BITS   = 1'b1;

    typedef struct packed {
        logic             leaf;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [SYM_W-1:0] symbol;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Start of one compressed byte, handed from the input side to the walker.
    typedef struct packed {
        logic             start;
        logic [SYM_W-1:0] data_byte;
        logic             final_byte;
    } walk_cmd_t;

    typedef struct packed {
        logic idle;
        logic pend_valid;
    } walk_stat_t;

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(NODE_COUNT);
    endfunction

    function automatic logic [NODE_AW-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
        return NODE_AW'(idx);
    endfunction

endpackage

FILE: sv/htd_ram.sv
`timescale 1ns / 1ps

module htd_ram #(
    parameter int  DEPTH = 512,
    parameter int  WIDTH = 27,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en_a,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en_a) begin
            rd_data_a_reg <= mem_array[rd_addr_a];
        end
        rd_data_b_reg <= mem_array[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

FILE: sv/htd_walker.sv
`timescale 1ns / 1ps

module htd_walker import htd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  walk_cmd_t         cmd,
    input  logic [IDX_W-1:0]  root_index,
    input  logic [PAD_W-1:0]  pad_bits,
    input  logic              root_wr,
    input  logic [IDX_W-1:0]  root_wr_index,
    input  logic [NODE_W-1:0] rd_data_a,
    input  logic [NODE_W-1:0] rd_data_b,
    output logic              rd_en,
    output logic [IDX_W-1:0]  rd_idx,
    output walk_stat_t        stat,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SYM_W-1:0]  m_symbol,
    output logic              m_run_end
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_FLUSH = 4'b1000
    } walk_state_t;

    walk_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [SYM_W-1:0]  byte_reg, byte_next;
    logic [BITS_W-1:0] bits_left_reg, bits_left_next;
    logic              final_reg, final_next;
    logic              oob_reg, oob_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]  pend_sym_reg, pend_sym_next;
    logic              m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]  m_symbol_reg, m_symbol_next;
    logic              m_run_end_reg, m_run_end_next;

    node_t            a_node;
    node_t            root_node;
    node_t            cur_node;
    logic             leaf_hit;
    logic             out_free;
    logic             stall;
    logic [IDX_W-1:0] child;

    // A read outside the table returns the all-zero node.
    assign a_node    = oob_reg ? '0 : node_t'(rd_data_a);
    assign root_node = idx_in_range(root_index) ? node_t'(rd_data_b) : '0;

    // The word in the read register is the node just stepped to; on a leaf
    // the walk continues from the root node, which port B always holds.
    assign leaf_hit = (state_reg == ST_WALK) && a_node.leaf;
    assign cur_node = leaf_hit ? root_node : a_node;
    assign child    = byte_reg[SYM_W-1] ? cur_node.right : cur_node.left;
    assign out_free = !m_valid_reg || m_ready;
    // With the read enable held low the memory output stays put during a stall.
    assign stall    = leaf_hit && pend_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        byte_next       = byte_reg;
        bits_left_next  = bits_left_reg;
        final_next      = final_reg;
        oob_next        = oob_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_symbol_next   = m_symbol_reg;
        m_run_end_next  = m_run_end_reg;
        rd_en           = 1'b0;
        rd_idx          = pos_reg;

        unique case (state_reg) inside
            ST_IDLE: begin
                // The root register takes the new index at this same edge.
                if (root_wr) begin
                    pos_next = root_wr_index;
                end
                if (cmd.start) begin
                    rd_en      = 1'b1;
                    rd_idx     = pos_reg;
                    byte_next  = cmd.data_byte;
                    final_next = cmd.final_byte;
                    bits_left_next = cmd.final_byte ?
                        BITS_W'(SYM_W) - BITS_W'(pad_bits) : BITS_W'(SYM_W);
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH, ST_WALK: begin
                if (!stall) begin
                    if (leaf_hit) begin
                        // The held symbol is known not to be the last of the byte.
                        if (pend_valid_reg) begin
                            m_valid_next   = 1'b1;
                            m_symbol_next  = pend_sym_reg;
                            m_run_end_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = a_node.symbol;
                        pos_next        = root_index;
                    end
                    if (bits_left_reg != '0) begin
                        rd_en          = 1'b1;
                        rd_idx         = child;
                        pos_next       = child;
                        byte_next      = byte_reg << 1;
                        bits_left_next = bits_left_reg - 1'b1;
                        state_next     = ST_WALK;
                    end else begin
                        if (final_reg) begin
                            pos_next = root_index;
                        end
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_symbol_next   = pend_sym_reg;
                    m_run_end_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (rd_en) begin
            oob_next = !idx_in_range(rd_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        byte_reg      <= byte_next;
        bits_left_reg <= bits_left_next;
        final_reg     <= final_next;
        oob_reg       <= oob_next;
        pend_sym_reg  <= pend_sym_next;
        m_symbol_reg  <= m_symbol_next;
        m_run_end_reg <= m_run_end_next;
    end

    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.pend_valid = pend_valid_reg;
    assign m_valid         = m_valid_reg;
    assign m_symbol        = m_symbol_reg;
    assign m_run_end       = m_run_end_reg;

endmodule

FILE: sv/huffman_tree_decoder.sv
`timescale 1ns / 1ps

// Huffman decoder that walks a code tree held in a 512-entry node table.
// A load word (cmd 0) writes one node and leaves the decoder idle. A data
// word (cmd 1) keeps s_ready low until its bits are walked and its last
// symbol, if any, is in the output register. The walk covers 8 bits, or
// 8 - pad_bits on the final byte: one node-table read is issued for the
// starting node and one per bit, and each result is needed before the next
// address is known, so the synchronous read latency of the table sets the
// pace. The walk stalls only while the symbol output is back-pressured.
// Decoded symbols appear one per transfer on the m_ channel, with m_run_end
// set on the last symbol of each input byte. The node table is not cleared
// at reset; walking into a node that was never loaded gives undefined
// symbols. Configuration writes (root index, padding bits) must be made
// while the decoder is idle; writing the root index also resets the walk.

module huffman_tree_decoder import htd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [IDX_W-1:0]      s_node_addr,
    input  logic                  s_node_is_leaf,
    input  logic [IDX_W-1:0]      s_node_left,
    input  logic [IDX_W-1:0]      s_node_right,
    input  logic [SYM_W-1:0]      s_node_symbol,
    input  logic [SYM_W-1:0]      s_data_byte,
    input  logic                  s_final_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SYM_W-1:0]      m_symbol,
    output logic                  m_run_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [IDX_W-1:0] root_index_reg;
    logic [PAD_W-1:0] pad_bits_reg;

    logic              s_accept;
    logic              wr_en;
    node_t             wr_node;
    logic              root_wr;
    walk_cmd_t         walk_cmd;
    walk_stat_t        walk_stat;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [NODE_W-1:0] rd_data_a;
    logic [NODE_W-1:0] rd_data_b;

    assign cfg_ready = 1'b1;
    assign root_wr   = cfg_valid && (cfg_index == CFG_ROOT_INDEX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_index_reg <= '0;
            pad_bits_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROOT_INDEX: root_index_reg <= cfg_data[IDX_W-1:0];
                CFG_PAD_BITS:   pad_bits_reg   <= cfg_data[PAD_W-1:0];
                default:        root_index_reg <= root_index_reg;
            endcase
        end
    end

    assign s_ready  = walk_stat.idle;
    assign s_accept = s_valid && s_ready;

    assign wr_en = s_accept && (s_cmd == CMD_LOAD) && idx_in_range(s_node_addr);
    assign wr_node.leaf   = s_node_is_leaf;
    assign wr_node.left   = s_node_left;
    assign wr_node.right  = s_node_right;
    assign wr_node.symbol = s_node_symbol;

    assign walk_cmd.start      = s_accept && (s_cmd == CMD_DATA);
    assign walk_cmd.data_byte  = s_data_byte;
    assign walk_cmd.final_byte = s_final_byte;

    htd_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (NODE_W)
    ) u_node_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (idx_to_addr(s_node_addr)),
        .wr_data   (wr_node),
        .rd_en_a   (rd_en),
        .rd_addr_a (idx_to_addr(rd_idx)),
        .rd_data_a (rd_data_a),
        .rd_addr_b (idx_to_addr(root_index_reg)),
        .rd_data_b (rd_data_b)
    );

    htd_walker u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (walk_cmd),
        .root_index    (root_index_reg),
        .pad_bits      (pad_bits_reg),
        .root_wr       (root_wr),
        .root_wr_index (cfg_data[IDX_W-1:0]),
        .rd_data_a     (rd_data_a),
        .rd_data_b     (rd_data_b),
        .rd_en         (rd_en),
        .rd_idx        (rd_idx),
        .stat          (walk_stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_run_end     (m_run_end)
    );

    // No symbol may still be held back once the decoder is ready for a word.
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_stat.idle |-> !walk_stat.pend_valid)
        else $error("decoder idle with a symbol still held");

    // A data byte always keeps the walker busy, so s_ready drops once it is taken.
    a_data_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_cmd == CMD_DATA)) |=> !s_ready)
        else $error("decoder ready right after taking a data byte");

    // A node load finishes in the cycle it is taken.
    a_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_cmd == CMD_LOAD)) |=> s_ready)
        else $error("decoder busy after a node load");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

import htd_pkg::*;

// One word on the s_ channel, all fields as driven on the ports.
typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] node_addr;
    logic             is_leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] node_sym;
    logic [SYM_W-1:0] byte_val;
    logic             last_byte;
} code_word_t;

typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             run_end;
} decoded_t;

class decode_scoreboard;
    node_t            node_mem [NODE_COUNT];
    logic [IDX_W-1:0] root_idx;
    logic [IDX_W-1:0] walk_pos;
    logic [PAD_W-1:0] pad_cnt;
    decoded_t         pending [$];
    int               errors;

    function new();
        foreach (node_mem[i]) node_mem[i] = '0;
        root_idx = '0;
        walk_pos = '0;
        pad_cnt  = '0;
        errors   = 0;
    endfunction

    function void note_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        if (idx == CFG_ROOT_INDEX) begin
            root_idx = value[IDX_W-1:0];
            walk_pos = root_idx;
        end else if (idx == CFG_PAD_BITS) begin
            pad_cnt = value[PAD_W-1:0];
        end
    endfunction

    // Records a node load, or walks the tree for one accepted data word and queues the symbols it yields.
    function void note_word(code_word_t w);
        node_t            nd;
        logic [IDX_W-1:0] pos;
        decoded_t         tail;
        int               nbits;
        int               base;
        if (w.cmd == CMD_LOAD) begin
            if (int'(w.node_addr) < NODE_COUNT)
                node_mem[w.node_addr] = '{leaf: w.is_leaf, left: w.left,
                                          right: w.right, symbol: w.node_sym};
            return;
        end
        nbits = w.last_byte ? 8 - int'(pad_cnt) : 8;
        pos   = walk_pos;
        base  = pending.size();
        for (int i = 0; i < nbits; i++) begin
            nd  = node_mem[pos];
            pos = w.byte_val[7 - i] ? nd.right : nd.left;
            if (node_mem[pos].leaf) begin
                pending.push_back('{symbol: node_mem[pos].symbol, run_end: 1'b0});
                pos = root_idx;
            end
        end
        if (pending.size() > base) begin
            tail         = pending.pop_back();
            tail.run_end = 1'b1;
            pending.push_back(tail);
        end
        walk_pos = w.last_byte ? root_idx : pos;
    endfunction

    function void check_result(logic [SYM_W-1:0] sym, logic run_end);
        decoded_t want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t: unexpected symbol word %02h run_end %0b", $time, sym, run_end);
        end else begin
            want = pending.pop_front();
            if (want.symbol !== sym || want.run_end !== run_end) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: symbol word wrong: expected %02h/%0b, got %02h/%0b",
                             $time, want.symbol, want.run_end, sym, run_end);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int SETTLE_CYCLES  = 24;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PRESSURE_PHASE = 3;
    localparam int WORD_TARGET    = 250;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_cmd          = CMD_LOAD;
    logic [IDX_W-1:0]      s_node_addr    = '0;
    logic                  s_node_is_leaf = 1'b0;
    logic [IDX_W-1:0]      s_node_left    = '0;
    logic [IDX_W-1:0]      s_node_right   = '0;
    logic [SYM_W-1:0]      s_node_symbol  = '0;
    logic [SYM_W-1:0]      s_data_byte    = '0;
    logic                  s_final_byte   = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [SYM_W-1:0]      m_symbol;
    logic                  m_run_end;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = CFG_ROOT_INDEX;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    decode_scoreboard sb;

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit rx_hold  = 1'b0;
    bit squeeze  = 1'b0;
    int words_sent = 0;
    int phase_no   = 0;

    // Current code tree: slot 0 is the root, children are referenced by slot.
    logic [IDX_W-1:0] t_addr [64];
    bit               t_leaf [64];
    int               t_lc [64];
    int               t_rc [64];
    int               t_count;
    bit               in_tree [NODE_COUNT];

    huffman_tree_decoder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_node_addr    (s_node_addr),
        .s_node_is_leaf (s_node_is_leaf),
        .s_node_left    (s_node_left),
        .s_node_right   (s_node_right),
        .s_node_symbol  (s_node_symbol),
        .s_data_byte    (s_data_byte),
        .s_final_byte   (s_final_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_run_end      (m_run_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic code_word_t load_word(logic [IDX_W-1:0] addr, logic leaf,
                                             logic [IDX_W-1:0] l, logic [IDX_W-1:0] r,
                                             logic [SYM_W-1:0] sym);
        code_word_t w;
        w.cmd       = CMD_LOAD;
        w.node_addr = addr;
        w.is_leaf   = leaf;
        w.left      = l;
        w.right     = r;
        w.node_sym  = sym;
        w.byte_val  = SYM_W'($urandom);
        w.last_byte = 1'($urandom);
        return w;
    endfunction

    function automatic code_word_t data_word(logic [SYM_W-1:0] value, logic last);
        code_word_t w;
        w.cmd       = CMD_DATA;
        w.node_addr = IDX_W'($urandom);
        w.is_leaf   = 1'($urandom);
        w.left      = IDX_W'($urandom);
        w.right     = IDX_W'($urandom);
        w.node_sym  = SYM_W'($urandom);
        w.byte_val  = value;
        w.last_byte = last;
        return w;
    endfunction

    function automatic logic [IDX_W-1:0] free_addr();
        logic [IDX_W-1:0] a;
        do a = IDX_W'($urandom_range(0, NODE_COUNT - 1)); while (in_tree[a]);
        return a;
    endfunction

    // Ends just after the accepting edge, so the next call can drive at the
    // following falling edge without a gap.
    task automatic send_word(input code_word_t w);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= w.cmd;
        s_node_addr    <= w.node_addr;
        s_node_is_leaf <= w.is_leaf;
        s_node_left    <= w.left;
        s_node_right   <= w.right;
        s_node_symbol  <= w.node_sym;
        s_data_byte    <= w.byte_val;
        s_final_byte   <= w.last_byte;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_cfg(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drop s_valid, wait for every symbol, then give a trailing walk time to end.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_slot(input int k);
        send_word(load_word(t_addr[k], t_leaf[k],
                            t_leaf[k] ? IDX_W'($urandom) : t_addr[t_lc[k]],
                            t_leaf[k] ? IDX_W'($urandom) : t_addr[t_rc[k]],
                            SYM_W'($urandom)));
    endtask

    // Grows a full binary tree by splitting random leaves, then loads its
    // nodes in shuffled order.
    task automatic plant_tree(input int leaves);
        int order [64];
        int j;
        int tmp;
        int grown;
        foreach (in_tree[a]) in_tree[a] = 1'b0;
        t_count   = 1;
        t_leaf[0] = 1'b1;
        t_addr[0] = free_addr();
        in_tree[t_addr[0]] = 1'b1;
        for (grown = 1; grown < leaves; grown++) begin
            do j = $urandom_range(0, t_count - 1); while (!t_leaf[j]);
            t_leaf[j] = 1'b0;
            t_lc[j]   = t_count;
            t_rc[j]   = t_count + 1;
            repeat (2) begin
                t_addr[t_count] = free_addr();
                in_tree[t_addr[t_count]] = 1'b1;
                t_leaf[t_count] = 1'b1;
                t_count++;
            end
        end
        for (int k = 0; k < t_count; k++) order[k] = k;
        for (int k = t_count - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < t_count; k++) load_slot(order[k]);
    endtask

    // A node write in the middle of a byte stream: either a fresh symbol for a
    // node of the live tree (shape kept) or junk outside the tree.
    task automatic stray_load();
        if ($urandom_range(0, 1) == 1)
            load_slot($urandom_range(0, t_count - 1));
        else
            send_word(load_word(free_addr(), 1'($urandom), IDX_W'($urandom),
                                IDX_W'($urandom), SYM_W'($urandom)));
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_symbol, m_run_end);
                stall = rx_quiet ? 0 : $urandom_range(0, 9);
            end else if (stall > 0 && !rx_hold) begin
                stall--;
            end
            @(negedge aclk);
            m_ready <= (stall == 0) && !rx_hold;
        end
    end

    // Starve the output long enough for the decoder to back up into s_ready.
    initial begin : output_hold
        wait (squeeze);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] pad_word;
        int                    n_bytes;
        bit                    last;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Tree rooted at 0, with children at 511 (the table end) and 1.
        send_word(load_word(9'd0,   1'b0, 9'd511, 9'd1,   8'hFF));
        send_word(load_word(9'd511, 1'b1, 9'd0,   9'd511, 8'hFF));
        send_word(load_word(9'd1,   1'b0, 9'd2,   9'd3,   8'h00));
        send_word(load_word(9'd2,   1'b1, 9'd511, 9'd0,   8'h00));
        send_word(load_word(9'd3,   1'b1, 9'h155, 9'h0AA, 8'hA5));
        settle();
        write_reg(CFG_ROOT_INDEX, 9'd0);
        write_reg(CFG_PAD_BITS, 9'h1F8);
        send_word(data_word(8'h00, 1'b0));
        send_word(data_word(8'hFF, 1'b0));
        send_word(data_word(8'h5A, 1'b0));
        send_word(data_word(8'h80, 1'b1));

        // Root at 511 and maximum padding: a final byte that walks one bit
        // and ends inside the tree yields nothing.
        send_word(load_word(9'd511, 1'b0, 9'd0,   9'd256, 8'h00));
        send_word(load_word(9'd0,   1'b1, 9'd511, 9'd511, 8'h3C));
        send_word(load_word(9'd256, 1'b0, 9'd300, 9'd7,   8'hFF));
        send_word(load_word(9'd300, 1'b1, 9'd0,   9'd0,   8'h00));
        send_word(load_word(9'd7,   1'b1, 9'd256, 9'd300, 8'hFF));
        settle();
        write_reg(CFG_PAD_BITS, 9'h007);
        write_reg(CFG_ROOT_INDEX, 9'd511);
        send_word(data_word(8'hFF, 1'b1));
        send_word(data_word(8'h80, 1'b0));
        send_word(data_word(8'h7F, 1'b1));
        send_word(data_word(8'hC0, 1'b0));

        while (words_sent < WORD_TARGET) begin
            phase_no++;
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            plant_tree(($urandom_range(0, 7) == 0) ? $urandom_range(12, 30)
                                                   : $urandom_range(2, 8));
            settle();
            pad_word = CFG_DATA_W'($urandom);
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_ROOT_INDEX, CFG_DATA_W'(t_addr[0]));
                write_reg(CFG_PAD_BITS, pad_word);
            end else begin
                write_reg(CFG_PAD_BITS, pad_word);
                write_reg(CFG_ROOT_INDEX, CFG_DATA_W'(t_addr[0]));
            end
            n_bytes = $urandom_range(3, 16);
            if (phase_no == PRESSURE_PHASE) begin
                n_bytes  = 24;
                tx_quiet = 1'b1;
                squeeze  = 1'b1;
            end
            // Streams usually close on a final byte; some stop mid-code so the
            // next root write has to restart the walk.
            for (int b = 0; b < n_bytes; b++) begin
                if ($urandom_range(0, 9) == 0) stray_load();
                last = (b == n_bytes - 1) ? ($urandom_range(0, 3) != 0)
                                          : ($urandom_range(0, 9) == 0);
                send_word(data_word(SYM_W'($urandom), last));
            end
        end
        settle();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
